// File: src/atr_pkg.sv
// ----------------------------------------------------------------------------
// atr_pkg
// Shared constants, codes and types of the alpha transfer ramp unit.
// ----------------------------------------------------------------------------
package atr_pkg;

   localparam int MAX_STOPS = 16;
   localparam int LEVELS    = 256;
   localparam int SLOT_W    = 4;
   localparam int CNT_W     = 5;
   localparam int LEVEL_W   = 8;
   localparam int FRAC_W    = 16;
   localparam int BYTE_W    = 8;
   localparam int STOP_W    = 2 * FRAC_W;
   localparam int PROD_W    = 2 * FRAC_W;
   localparam int DIVD_W    = PROD_W + BYTE_W + 1;
   localparam int QCNT_W    = $clog2(BYTE_W);

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_EVAL  = 1'b1
   } atr_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SCAN,
      ST_CALC
   } atr_state_type;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_MUL,
      CS_SUM,
      CS_DIV
   } atr_calc_state_type;

   typedef struct packed {
      logic              go;
      logic [FRAC_W-1:0] a_lo;
      logic [FRAC_W-1:0] a_hi;
      logic [FRAC_W-1:0] w;
      logic [FRAC_W-1:0] d;
   } atr_calc_req_type;

   typedef struct packed {
      logic              done;
      logic [BYTE_W-1:0] alpha_byte;
   } atr_calc_rsp_type;

endpackage

// File: src/atr_ram.sv
// ----------------------------------------------------------------------------
// atr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module atr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/atr_calc.sv
// ----------------------------------------------------------------------------
// atr_calc
// Interpolation arithmetic: two products, a scaled sum and an 8-step
// restoring division that yields the rounded alpha byte.
// ----------------------------------------------------------------------------
module atr_calc import atr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  atr_calc_req_type req,
   output atr_calc_rsp_type rsp
);

   atr_calc_state_type state_ff, state_in;
   logic [FRAC_W-1:0]  a_lo_ff, a_lo_in;
   logic [FRAC_W-1:0]  a_hi_ff, a_hi_in;
   logic [FRAC_W-1:0]  w_ff, w_in;
   logic [FRAC_W-1:0]  d_ff, d_in;
   logic [PROD_W-1:0]  p1_ff, p1_in;
   logic [PROD_W-1:0]  p2_ff, p2_in;
   logic [DIVD_W-1:0]  rem_ff, rem_in;
   logic [DIVD_W-1:0]  dsh_ff, dsh_in;
   logic [BYTE_W-1:0]  q_ff, q_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic [PROD_W-1:0]  num;
   logic [PROD_W-1:0]  den;
   logic [DIVD_W-1:0]  num_ext;
   logic               q_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_lo_ff <= a_lo_in;
      a_hi_ff <= a_hi_in;
      w_ff    <= w_in;
      d_ff    <= d_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      a_lo_in  = a_lo_ff;
      a_hi_in  = a_hi_ff;
      w_in     = w_ff;
      d_in     = d_ff;
      p1_in    = p1_ff;
      p2_in    = p2_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      num      = p1_ff + p2_ff;
      den      = {w_ff, {FRAC_W{1'b0}}} - {{FRAC_W{1'b0}}, w_ff};
      num_ext  = DIVD_W'(num);
      q_bit    = (rem_ff >= dsh_ff);
      rsp.done       = 1'b0;
      rsp.alpha_byte = {q_ff[BYTE_W-2:0], q_bit};
      unique case (state_ff)
         CS_IDLE: begin
            if (req.go) begin
               a_lo_in  = req.a_lo;
               a_hi_in  = req.a_hi;
               w_in     = req.w;
               d_in     = req.d;
               state_in = CS_MUL;
            end
         end
         CS_MUL: begin
            p1_in    = a_lo_ff * (w_ff - d_ff);
            p2_in    = a_hi_ff * d_ff;
            state_in = CS_SUM;
         end
         CS_SUM: begin
            rem_in   = (num_ext << BYTE_W) - num_ext + DIVD_W'(den >> 1);
            dsh_in   = DIVD_W'(den) << (BYTE_W - 1);
            q_in     = '0;
            cnt_in   = QCNT_W'(BYTE_W - 1);
            state_in = CS_DIV;
         end
         CS_DIV: begin
            if (q_bit) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in = dsh_ff >> 1;
            q_in   = {q_ff[BYTE_W-2:0], q_bit};
            cnt_in = cnt_ff - QCNT_W'(1);
            if (cnt_ff == '0) begin
               rsp.done = 1'b1;
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

// File: src/atr_ctrl.sv
// ----------------------------------------------------------------------------
// atr_ctrl
// Sequencer: stores stops, walks the stop memory to find the segment that
// holds t, hands the operands to the arithmetic and presents the result.
// ----------------------------------------------------------------------------
module atr_ctrl import atr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [SLOT_W-1:0] req_stop_slot,
   input  logic [FRAC_W-1:0] req_stop_position,
   input  logic [FRAC_W-1:0] req_stop_alpha,
   input  logic [LEVEL_W-1:0] req_level,
   input  logic [CNT_W-1:0]  stop_count,
   output logic              ram_wr_en,
   output logic [SLOT_W-1:0] ram_wr_addr,
   output logic [STOP_W-1:0] ram_wr_data,
   output logic [SLOT_W-1:0] ram_rd_addr,
   input  logic [STOP_W-1:0] ram_rd_data,
   output atr_calc_req_type  calc_req,
   input  atr_calc_rsp_type  calc_rsp,
   output logic              rsp_strobe,
   output logic [LEVEL_W-1:0] rsp_gray_value,
   output logic [BYTE_W-1:0] rsp_alpha_byte
);

   atr_state_type      state_ff, state_in;
   logic [FRAC_W-1:0]  t_ff, t_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [FRAC_W-1:0]  lo_p_ff, lo_p_in;
   logic [FRAC_W-1:0]  lo_a_ff, lo_a_in;
   logic [FRAC_W-1:0]  last_a_ff, last_a_in;
   logic               strobe_ff, strobe_in;
   logic [LEVEL_W-1:0] gray_ff, gray_in;
   logic [BYTE_W-1:0]  alpha_ff, alpha_in;
   logic [FRAC_W-1:0]  r_pos;
   logic [FRAC_W-1:0]  r_alpha;
   logic [CNT_W-1:0]   n_clamp;
   logic [CNT_W-1:0]   last_idx;
   logic [CNT_W-1:0]   idx_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      t_ff      <= t_in;
      level_ff  <= level_in;
      n_ff      <= n_in;
      idx_ff    <= idx_in;
      lo_p_ff   <= lo_p_in;
      lo_a_ff   <= lo_a_in;
      last_a_ff <= last_a_in;
      gray_ff   <= gray_in;
      alpha_ff  <= alpha_in;
   end

   assign r_pos    = ram_rd_data[STOP_W-1:FRAC_W];
   assign r_alpha  = ram_rd_data[FRAC_W-1:0];
   assign n_clamp  = (stop_count > CNT_W'(MAX_STOPS)) ? CNT_W'(MAX_STOPS) : stop_count;
   assign last_idx = n_ff - CNT_W'(1);
   assign idx_nx   = idx_ff + CNT_W'(1);

   always_comb begin
      state_in  = state_ff;
      t_in      = t_ff;
      level_in  = level_ff;
      n_in      = n_ff;
      idx_in    = idx_ff;
      lo_p_in   = lo_p_ff;
      lo_a_in   = lo_a_ff;
      last_a_in = last_a_ff;
      strobe_in = 1'b0;
      gray_in   = gray_ff;
      alpha_in  = alpha_ff;
      busy        = (state_ff != ST_IDLE);
      ram_wr_en   = 1'b0;
      ram_wr_addr = req_stop_slot;
      ram_wr_data = {req_stop_position, req_stop_alpha};
      ram_rd_addr = '0;
      calc_req.go   = 1'b0;
      calc_req.a_lo = '0;
      calc_req.a_hi = '0;
      calc_req.w    = FRAC_W'(1);
      calc_req.d    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_operation == OP_WRITE) begin
                  ram_wr_en = 1'b1;
               end else begin
                  t_in     = {req_level, req_level};
                  level_in = req_level;
                  n_in     = n_clamp;
                  if (n_clamp == '0) begin
                     calc_req.go   = 1'b1;
                     calc_req.a_lo = {req_level, req_level};
                     state_in      = ST_CALC;
                  end else begin
                     ram_rd_addr = '0;
                     state_in    = ST_FIRST;
                  end
               end
            end
         end
         ST_FIRST: begin
            lo_p_in = r_pos;
            lo_a_in = r_alpha;
            if (t_ff <= r_pos) begin
               calc_req.go   = 1'b1;
               calc_req.a_lo = r_alpha;
               state_in      = ST_CALC;
            end else begin
               ram_rd_addr = last_idx[SLOT_W-1:0];
               state_in    = ST_LAST;
            end
         end
         ST_LAST: begin
            last_a_in = r_alpha;
            if (t_ff >= r_pos) begin
               calc_req.go   = 1'b1;
               calc_req.a_lo = r_alpha;
               state_in      = ST_CALC;
            end else begin
               ram_rd_addr = SLOT_W'(1);
               idx_in      = CNT_W'(1);
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (t_ff <= r_pos) begin
               calc_req.go = 1'b1;
               state_in    = ST_CALC;
               if (r_pos <= lo_p_ff || t_ff < lo_p_ff) begin
                  calc_req.a_lo = lo_a_ff;
               end else begin
                  calc_req.a_lo = lo_a_ff;
                  calc_req.a_hi = r_alpha;
                  calc_req.w    = r_pos - lo_p_ff;
                  calc_req.d    = t_ff - lo_p_ff;
               end
            end else begin
               lo_p_in = r_pos;
               lo_a_in = r_alpha;
               idx_in  = idx_nx;
               if (idx_nx == n_ff) begin
                  calc_req.go   = 1'b1;
                  calc_req.a_lo = last_a_ff;
                  state_in      = ST_CALC;
               end else begin
                  ram_rd_addr = idx_nx[SLOT_W-1:0];
               end
            end
         end
         ST_CALC: begin
            if (calc_rsp.done) begin
               strobe_in = 1'b1;
               gray_in   = level_ff;
               alpha_in  = calc_rsp.alpha_byte;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_gray_value = gray_ff;
   assign rsp_alpha_byte = alpha_ff;

endmodule

// File: src/alpha_transfer_ramp_unit.sv
// ----------------------------------------------------------------------------
// alpha_transfer_ramp_unit
// Gray ramp transfer-table entry builder with piecewise linear opacity.
// ----------------------------------------------------------------------------
// A beat is accepted on a rising edge with start high and busy low. A write
// beat (req_operation low) stores one stop and gives no result.
// An evaluate beat gives one result on rsp_gray_value and rsp_alpha_byte,
// marked by rsp_strobe for exactly one cycle; the receiver cannot stall it.
// The stop count register is written through the csr_ channel while the
// block is idle.
// An evaluate beat with no stops goes straight to the arithmetic; with
// stops, the segment search may walk the whole stop memory, one stop read
// per cycle from its single read port. The arithmetic after the search
// is two products, one sum and an eight-step division. busy falls in the
// strobe cycle, so the next beat may be accepted there. Reset clears the
// sequencer and the stop count; stop memory contents are undefined until
// written.
// ----------------------------------------------------------------------------
module alpha_transfer_ramp_unit import atr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [SLOT_W-1:0]  req_stop_slot,
   input  logic [FRAC_W-1:0]  req_stop_position,
   input  logic [FRAC_W-1:0]  req_stop_alpha,
   input  logic [LEVEL_W-1:0] req_level,
   output logic               rsp_strobe,
   output logic [LEVEL_W-1:0] rsp_gray_value,
   output logic [BYTE_W-1:0]  rsp_alpha_byte,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CNT_W-1:0]   csr_stop_count
);

   logic [CNT_W-1:0]  stop_count_ff, stop_count_in;
   logic              ram_wr_en;
   logic [SLOT_W-1:0] ram_wr_addr;
   logic [STOP_W-1:0] ram_wr_data;
   logic [SLOT_W-1:0] ram_rd_addr;
   logic [STOP_W-1:0] ram_rd_data;
   atr_calc_req_type  calc_req;
   atr_calc_rsp_type  calc_rsp;

   assign csr_ready     = ~busy;
   assign stop_count_in = (csr_valid && csr_ready) ? csr_stop_count : stop_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= '0;
      end else begin
         stop_count_ff <= stop_count_in;
      end
   end

   atr_ram #(
      .WIDTH (STOP_W),
      .DEPTH (MAX_STOPS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   atr_calc u_calc (
      .clock (clock),
      .reset (reset),
      .req   (calc_req),
      .rsp   (calc_rsp)
   );

   atr_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_stop_slot     (req_stop_slot),
      .req_stop_position (req_stop_position),
      .req_stop_alpha    (req_stop_alpha),
      .req_level         (req_level),
      .stop_count        (stop_count_ff),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .calc_req          (calc_req),
      .calc_rsp          (calc_rsp),
      .rsp_strobe        (rsp_strobe),
      .rsp_gray_value    (rsp_gray_value),
      .rsp_alpha_byte    (rsp_alpha_byte)
   );

endmodule

// File: src/atr_checker.sv
// ----------------------------------------------------------------------------
// atr_checker
// Port-level checks of the alpha transfer ramp unit, bound to the top level.
// ----------------------------------------------------------------------------
module atr_checker import atr_pkg::*; (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_operation,
   input logic rsp_strobe
);

   a_eval_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_EVAL) |=> busy)
      else $error("evaluate beat did not raise busy");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_operation == OP_WRITE) |=> (!busy && !rsp_strobe))
      else $error("write beat produced a result or held busy");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of an evaluation");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe lasted more than one cycle");

endmodule

bind alpha_transfer_ramp_unit atr_checker u_atr_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_operation (req_operation),
   .rsp_strobe    (rsp_strobe)
);

// File: dv/alpha_transfer_ramp_unit_test.sv
// ----------------------------------------------------------------------------
// alpha_transfer_ramp_unit_test
// Self-checking bench for the gray ramp transfer-table entry builder.
// ----------------------------------------------------------------------------
// A queue of stop-write and level-evaluate beats feeds a clocked driver that
// holds each beat on the request ports until the block takes it. At every
// accepted beat an in-bench model of the stop memory stores a stop or predicts
// the table entry, and a clocked monitor compares each strobed result against
// the oldest prediction. The stop count is changed between phases while idle.
// ----------------------------------------------------------------------------
module alpha_transfer_ramp_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import atr_pkg::*;

   localparam int          SETTLE_CYCLES  = 40;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          RANDOM_PHASES  = 12;
   localparam int          PHASE_BEATS    = 90;
   localparam int          MAX_REPORTS    = 10;
   localparam int          GAP_PERCENT    = 26;
   localparam int          POS_W          = FRAC_W + 1;
   localparam logic [63:0] FULL_SCALE     = 64'd65535;
   localparam logic [63:0] LEVEL_STEP     = 64'd257;

   typedef struct packed {
      atr_op_type         op;
      logic [SLOT_W-1:0]  slot;
      logic [FRAC_W-1:0]  position;
      logic [FRAC_W-1:0]  alpha;
      logic [LEVEL_W-1:0] level;
   } ramp_beat_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] gray;
      logic [BYTE_W-1:0]  alpha;
   } table_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_operation = 1'b0;
   logic [SLOT_W-1:0]  req_stop_slot = '0;
   logic [FRAC_W-1:0]  req_stop_position = '0;
   logic [FRAC_W-1:0]  req_stop_alpha = '0;
   logic [LEVEL_W-1:0] req_level = '0;
   logic               rsp_strobe;
   logic [LEVEL_W-1:0] rsp_gray_value;
   logic [BYTE_W-1:0]  rsp_alpha_byte;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CNT_W-1:0]   csr_stop_count = '0;

   ramp_beat_type      pending_beats[$];
   ramp_beat_type      driven_beat;
   table_entry_type    entries_due[$];
   logic [FRAC_W-1:0]  ramp_pos[MAX_STOPS];
   logic [FRAC_W-1:0]  ramp_alpha[MAX_STOPS];
   logic [CNT_W-1:0]   ramp_count = '0;
   bit                 steady = 1'b0;
   int                 faults = 0;
   int                 stall_cycles = 0;

   alpha_transfer_ramp_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_stop_slot     (req_stop_slot),
      .req_stop_position (req_stop_position),
      .req_stop_alpha    (req_stop_alpha),
      .req_level         (req_level),
      .rsp_strobe        (rsp_strobe),
      .rsp_gray_value    (rsp_gray_value),
      .rsp_alpha_byte    (rsp_alpha_byte),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_stop_count    (csr_stop_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [BYTE_W-1:0] to_alpha_byte(input logic [63:0] a);
      logic [63:0] q;
      q = (a * 64'd255 + FULL_SCALE / 64'd2) / FULL_SCALE;
      return q[BYTE_W-1:0];
   endfunction

   function automatic logic [BYTE_W-1:0] alpha_for_level(input logic [LEVEL_W-1:0] lvl);
      logic [63:0]       t;
      logic [63:0]       w;
      logic [63:0]       d;
      logic [63:0]       num;
      logic [63:0]       den;
      logic [63:0]       q;
      logic [BYTE_W-1:0] b;
      int                n;
      bit                found;
      t = LEVEL_STEP * lvl;
      n = (ramp_count > MAX_STOPS) ? MAX_STOPS : int'(ramp_count);
      found = 1'b0;
      if (n == 0) begin
         b = to_alpha_byte(t);
      end else if (t <= ramp_pos[0]) begin
         b = to_alpha_byte(ramp_alpha[0]);
      end else if (t >= ramp_pos[n-1]) begin
         b = to_alpha_byte(ramp_alpha[n-1]);
      end else begin
         b = to_alpha_byte(ramp_alpha[n-1]);
         for (int i = 1; i < n; i++) begin
            if (!found && t <= ramp_pos[i]) begin
               found = 1'b1;
               if (ramp_pos[i] <= ramp_pos[i-1] || t < ramp_pos[i-1]) begin
                  b = to_alpha_byte(ramp_alpha[i-1]);
               end else begin
                  w = ramp_pos[i] - ramp_pos[i-1];
                  d = t - ramp_pos[i-1];
                  num = ramp_alpha[i-1] * (w - d) + ramp_alpha[i] * d;
                  den = FULL_SCALE * w;
                  q = (num * 64'd255 + den / 64'd2) / den;
                  b = q[BYTE_W-1:0];
               end
            end
         end
      end
      return b;
   endfunction

   task automatic take_beat(input ramp_beat_type b);
      table_entry_type e;
      if (b.op == OP_WRITE) begin
         ramp_pos[b.slot] = b.position;
         ramp_alpha[b.slot] = b.alpha;
      end else begin
         e.gray = b.level;
         e.alpha = alpha_for_level(b.level);
         entries_due.push_back(e);
      end
   endtask

   always @(posedge clock) begin : driver
      logic issue;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            take_beat(driven_beat);
         end
         if (!start || !busy) begin
            issue = pending_beats.size() > 0 &&
                    (steady || $urandom_range(0, 99) >= GAP_PERCENT);
            if (issue) begin
               driven_beat = pending_beats.pop_front();
               req_operation <= driven_beat.op;
               req_stop_slot <= driven_beat.slot;
               req_stop_position <= driven_beat.position;
               req_stop_alpha <= driven_beat.alpha;
               req_level <= driven_beat.level;
            end
            start <= issue;
         end
      end
   end

   always @(posedge clock) begin : monitor
      table_entry_type e;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            ramp_count = csr_stop_count;
         end
         if (rsp_strobe) begin
            if (entries_due.size() == 0) begin
               faults++;
               if (faults <= MAX_REPORTS) begin
                  $display("unexpected result: gray %0d alpha %0d",
                           rsp_gray_value, rsp_alpha_byte);
               end
            end else begin
               e = entries_due.pop_front();
               if (rsp_gray_value !== e.gray || rsp_alpha_byte !== e.alpha) begin
                  faults++;
                  if (faults <= MAX_REPORTS) begin
                     $display("mismatch: expected gray %0d alpha %0d, got gray %0d alpha %0d",
                              e.gray, e.alpha, rsp_gray_value, rsp_alpha_byte);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("alpha_transfer_ramp_unit verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic ramp_beat_type random_beat();
      ramp_beat_type b;
      b.op = atr_op_type'($urandom_range(0, 1));
      b.slot = SLOT_W'($urandom);
      b.position = FRAC_W'($urandom);
      b.alpha = FRAC_W'($urandom);
      b.level = LEVEL_W'($urandom);
      return b;
   endfunction

   function automatic logic [FRAC_W-1:0] random_alpha();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         default: return FRAC_W'($urandom);
      endcase
   endfunction

   task automatic queue_write(input int slot, input logic [FRAC_W-1:0] position,
                              input logic [FRAC_W-1:0] alpha);
      ramp_beat_type b;
      b = random_beat();
      b.op = OP_WRITE;
      b.slot = SLOT_W'(slot);
      b.position = position;
      b.alpha = alpha;
      pending_beats.push_back(b);
   endtask

   task automatic queue_level(input logic [LEVEL_W-1:0] lvl);
      ramp_beat_type b;
      b = random_beat();
      b.op = OP_EVAL;
      b.level = lvl;
      pending_beats.push_back(b);
   endtask

   task automatic queue_sorted_stops(input int span);
      logic [POS_W-1:0] pos;
      int               k;
      k = (span == 0) ? MAX_STOPS : span;
      pos = ($urandom_range(0, 3) == 0) ? '0 : POS_W'($urandom_range(0, 8000));
      for (int i = 0; i < k; i++) begin
         queue_write(i, pos[FRAC_W-1:0], random_alpha());
         if ($urandom_range(0, 7) != 0) begin
            pos = pos + POS_W'($urandom_range(0, 131070 / k));
         end
         if (pos > FULL_SCALE) begin
            pos = FULL_SCALE[POS_W-1:0];
         end
      end
   endtask

   task automatic queue_random_phase(input int span);
      int queued;
      int roll;
      queued = 0;
      while (queued < PHASE_BEATS) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            queue_sorted_stops(span);
            queued += (span == 0) ? MAX_STOPS : span;
         end else if (roll < 22) begin
            queue_write($urandom_range(0, MAX_STOPS - 1), FRAC_W'($urandom),
                        random_alpha());
            queued++;
         end else begin
            queue_level(LEVEL_W'($urandom));
            queued++;
         end
      end
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_beats.size() > 0 || start || entries_due.size() > 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_stop_count(input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_stop_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : sequencer
      logic [CNT_W-1:0] count;
      int               span;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_level(0);
      queue_level(255);
      queue_level(128);
      queue_level(1);
      for (int i = 0; i < MAX_STOPS; i++) begin
         queue_write(i, (i == 2) ? 16'd4369 : 16'(i * 4369),
                     (i % 3 == 0) ? 16'hFFFF : (i % 3 == 1) ? 16'h0000 : 16'(i * 4000));
      end
      drain();
      write_stop_count(5'd16);
      queue_level(0);
      queue_level(255);
      queue_level(17);
      queue_level(18);
      queue_level(100);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: count = 5'd0;
            1: count = 5'd1;
            2: count = 5'd2;
            3: count = 5'd16;
            4: count = 5'd31;
            5: count = 5'd15;
            default: count = CNT_W'($urandom_range(0, 31));
         endcase
         span = (count > MAX_STOPS) ? MAX_STOPS : int'(count);
         write_stop_count(count);
         steady = (p == 4);
         queue_random_phase(span);
         drain();
      end

      if (faults == 0 && entries_due.size() == 0) begin
         $display("alpha_transfer_ramp_unit verification clean");
      end else begin
         $display("alpha_transfer_ramp_unit verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
src/atr_pkg.sv
src/atr_ram.sv
src/atr_calc.sv
src/atr_ctrl.sv
src/alpha_transfer_ramp_unit.sv
src/atr_checker.sv
dv/alpha_transfer_ramp_unit_test.sv
